[rtl/ile_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

	// Default number of list slots (one cell each).
	localparam int DEPTH_DEF = 256;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 16;
	localparam int OP_W      = 3;
	localparam int COUNT_O_W = 9;

	// Word returned by a rejected read.
	localparam logic [DATA_W-1:0] READ_FAIL = '1;

	typedef enum logic [OP_W-1:0] {
		OP_READ     = 3'd0,
		OP_INS_HEAD = 3'd1,
		OP_APPEND   = 3'd2,
		OP_INS_AT   = 3'd3,
		OP_DELETE   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell of the chain does in one cycle.
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT_L,
		CMD_ROT_R
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

[rtl/ile_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ile_cell #(
	parameter int INDEX = 0
) (
	input  wire                          clk,
	input  wire  ile_pkg::cell_cmd_t     cmd,
	input  wire  [ile_pkg::DATA_W-1:0]   lower,
	input  wire  [ile_pkg::DATA_W-1:0]   upper,
	output logic [ile_pkg::DATA_W-1:0]   entry
);

	localparam logic [ile_pkg::POS_W-1:0] MY_POS = ile_pkg::POS_W'(INDEX);

	logic [ile_pkg::DATA_W-1:0] entry_q;

	// Each slot takes its own word, a neighbor's word, or the new value.
	always_ff @(posedge clk) begin
		case (cmd.kind)
			ile_pkg::CMD_INS: begin
				if (MY_POS > cmd.pos) begin
					entry_q <= lower;
				end else if (MY_POS == cmd.pos) begin
					entry_q <= cmd.value;
				end
			end
			ile_pkg::CMD_DEL: begin
				if (MY_POS >= cmd.pos) begin
					entry_q <= upper;
				end
			end
			ile_pkg::CMD_ROT_L: entry_q <= upper;
			ile_pkg::CMD_ROT_R: entry_q <= lower;
			default: ;
		endcase
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

[rtl/ile_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

module ile_chain #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
	input  wire                          clk,
	input  wire  ile_pkg::cell_cmd_t     cmd,
	output logic [ile_pkg::DATA_W-1:0]   head
);

	logic [ile_pkg::DATA_W-1:0] ent [DEPTH];

	// The row is closed into a ring so that rotation can bring any slot to the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ile_pkg::DATA_W-1:0] lo, up;

		if (i == 0) begin : g_first
			assign lo = ent[DEPTH-1];
		end else begin : g_lo
			assign lo = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign up = ent[0];
		end else begin : g_up
			assign up = ent[i+1];
		end

		ile_cell #(
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.lower (lo),
			.upper (up),
			.entry (ent[i])
		);
	end

	assign head = ent[0];

endmodule

`default_nettype wire

[rtl/indexed_list_engine_unit.sv]
// Insert, append, delete, a rejected request and a read at position 0 are answered from
// one register: the result word is valid in the cycle after the input word is accepted.
// A read at position p > 0 rotates the cell ring p steps toward the head and p steps
// back (states S_FWD, S_GRAB, S_BACK); only then is its result valid and a new word taken;
// other requests take one word per cycle while the result side is ready.
// Reset (arst_n low) empties the list and the output register; slots are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_unit #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [47:0] s_axis_tdata,   // [15:0] position, [47:16] value
	input  wire  [2:0]  s_axis_tuser,   // [2:0] op

	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [31:0] read_value, [40:32] count_now, rest zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FWD,
		S_GRAB,
		S_BACK
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   count_q;
	logic [IW-1:0]                   rot_q;
	logic [IW-1:0]                   pos_q;
	logic                            out_valid_q;
	logic [ile_pkg::DATA_W-1:0]      out_value_q;
	ile_pkg::status_t                out_status_q;
	logic [ile_pkg::COUNT_O_W-1:0]   out_count_q;

	logic                            accept;
	ile_pkg::op_t                    op;
	logic [ile_pkg::POS_W-1:0]       pos_in;
	logic [ile_pkg::DATA_W-1:0]      value_in;
	logic [31:0]                     pos_ext, cnt_ext, ipos_ext, cnt_next_ext;
	logic [CW-1:0]                   cnt_next;
	ile_pkg::cell_cmd_t              acc_cmd, chain_cmd;
	logic [ile_pkg::DATA_W-1:0]      res_value;
	ile_pkg::status_t                res_status;
	logic                            go_rotate;
	logic [ile_pkg::DATA_W-1:0]      head;

	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign op       = ile_pkg::op_t'(s_axis_tuser);
	assign pos_in   = s_axis_tdata[15:0];
	assign value_in = s_axis_tdata[47:16];
	assign pos_ext  = 32'(pos_in);
	assign cnt_ext  = 32'(count_q);

	// Decode the incoming word: range and capacity checks, chain command, result.
	always_comb begin
		acc_cmd.kind  = ile_pkg::CMD_HOLD;
		acc_cmd.pos   = pos_in;
		acc_cmd.value = value_in;
		res_value     = '0;
		res_status    = ile_pkg::ST_RANGE;
		cnt_next      = count_q;
		go_rotate     = 1'b0;
		ipos_ext      = pos_ext;
		case (op)
			ile_pkg::OP_READ: begin
				if (pos_ext < cnt_ext) begin
					res_status = ile_pkg::ST_DONE;
					res_value  = head;
					go_rotate  = (pos_ext != 32'd0);
				end else begin
					res_value = ile_pkg::READ_FAIL;
				end
			end
			ile_pkg::OP_INS_HEAD, ile_pkg::OP_APPEND, ile_pkg::OP_INS_AT: begin
				if (op == ile_pkg::OP_INS_HEAD) begin
					ipos_ext = 32'd0;
				end else if (op == ile_pkg::OP_APPEND) begin
					ipos_ext = cnt_ext;
				end
				if (ipos_ext > cnt_ext) begin
					res_status = ile_pkg::ST_RANGE;
				end else if (cnt_ext >= 32'(DEPTH)) begin
					res_status = ile_pkg::ST_FULL;
				end else begin
					res_status   = ile_pkg::ST_DONE;
					acc_cmd.kind = ile_pkg::CMD_INS;
					acc_cmd.pos  = ipos_ext[ile_pkg::POS_W-1:0];
					cnt_next     = count_q + CW'(1);
				end
			end
			ile_pkg::OP_DELETE: begin
				if (pos_ext < cnt_ext) begin
					res_status   = ile_pkg::ST_DONE;
					acc_cmd.kind = ile_pkg::CMD_DEL;
					cnt_next     = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign cnt_next_ext = 32'(cnt_next);

	// Command broadcast to every cell of the chain.
	always_comb begin
		chain_cmd.pos   = acc_cmd.pos;
		chain_cmd.value = acc_cmd.value;
		case (state_q)
			S_IDLE:  chain_cmd.kind = (accept && !go_rotate) ? acc_cmd.kind : ile_pkg::CMD_HOLD;
			S_FWD:   chain_cmd.kind = ile_pkg::CMD_ROT_L;
			S_BACK:  chain_cmd.kind = ile_pkg::CMD_ROT_R;
			default: chain_cmd.kind = ile_pkg::CMD_HOLD;
		endcase
	end

	ile_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk  (clk),
		.cmd  (chain_cmd),
		.head (head)
	);

	// Sequencer: count, rotation for reads, and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rot_q        <= '0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ile_pkg::ST_DONE;
			out_count_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// A pending word leaves when taken; a request that needs no rotation refills it.
					if (accept && !go_rotate) begin
						out_valid_q <= 1'b1;
					end else if (m_axis_tready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						count_q <= cnt_next;
						if (go_rotate) begin
							rot_q   <= IW'(pos_in);
							pos_q   <= IW'(pos_in);
							state_q <= S_FWD;
						end else begin
							out_value_q  <= res_value;
							out_status_q <= res_status;
							out_count_q  <= cnt_next_ext[ile_pkg::COUNT_O_W-1:0];
						end
					end
				end
				S_FWD: begin
					rot_q <= rot_q - IW'(1);
					if (rot_q == IW'(1)) begin
						state_q <= S_GRAB;
					end
				end
				S_GRAB: begin
					out_value_q  <= head;
					out_status_q <= ile_pkg::ST_DONE;
					out_count_q  <= cnt_ext[ile_pkg::COUNT_O_W-1:0];
					rot_q        <= pos_q;
					state_q      <= S_BACK;
				end
				S_BACK: begin
					rot_q <= rot_q - IW'(1);
					if (rot_q == IW'(1)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_count_q, out_value_q};
	assign m_axis_tuser  = out_status_q;

	// The list never holds more words than there are cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= 32'(DEPTH))
		else $error("list count exceeds depth");

	// New words are taken only while the ring sits in its home position.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == S_IDLE))
		else $error("input ready while rotating");

	// Any request other than a read answers in the next cycle.
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op != ile_pkg::OP_READ)) |=> m_axis_tvalid)
		else $error("missing single-cycle result");

	// A rotation never starts or runs with an empty step counter.
	a_rot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FWD) || (state_q == S_BACK)) |-> (rot_q != '0))
		else $error("rotation counter is zero");

	// The count does not change while a read rotates the ring.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("count changed during a read");

endmodule

`default_nettype wire

[bench/tb_indexed_list_engine_unit.sv]
`timescale 1ns / 1ps

module tb_indexed_list_engine_unit;

	localparam int DEPTH      = ile_pkg::DEPTH_DEF;
	localparam int DATA_W     = ile_pkg::DATA_W;
	localparam int POS_W      = ile_pkg::POS_W;
	localparam int OP_W       = ile_pkg::OP_W;
	localparam int COUNT_O_W  = ile_pkg::COUNT_O_W;
	localparam int RAND_ITEMS = 1400;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_MAX  = 20000;

	// One result word as the list produces it.
	typedef struct packed {
		logic [DATA_W-1:0]    rv;
		ile_pkg::status_t     st;
		logic [COUNT_O_W-1:0] cnt;
	} list_result_t;

	// One row of the directed sequence; fixed_res is used when has_fixed is set.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		logic              has_fixed;
		list_result_t      fixed_res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// Shadow copy of the list.
	logic [DATA_W-1:0] list_mem [DEPTH];
	int                list_len = 0;

	list_result_t pending_q [$];
	dir_row_t     dir_rows [$];

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int random_sent = 0;
	int n_reads = 0, n_inserts = 0, n_deletes = 0, n_range = 0, n_full = 0, peak_len = 0;
	int quiet_cycles = 0;

	indexed_list_engine_unit #(.DEPTH(DEPTH)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [15:0] position, [47:16] value
		.s_axis_tuser  (s_axis_tuser),   // [2:0] op
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [31:0] read_value, [40:32] count_now
		.m_axis_tuser  (m_axis_tuser)    // [1:0] status
	);

	always #4 clk = ~clk;

	// Apply one request to the shadow list and return the word it should produce.
	function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
		list_result_t r;
		int           p;
		r.rv = '0;
		r.st = ile_pkg::ST_DONE;
		case (op)
			ile_pkg::OP_READ: begin
				n_reads++;
				if (int'(pos) < list_len) begin
					r.rv = list_mem[int'(pos)];
				end else begin
					r.rv = ile_pkg::READ_FAIL;
					r.st = ile_pkg::ST_RANGE;
				end
			end
			ile_pkg::OP_INS_HEAD, ile_pkg::OP_APPEND, ile_pkg::OP_INS_AT: begin
				p = (op == ile_pkg::OP_INS_HEAD) ? 0 :
					(op == ile_pkg::OP_APPEND) ? list_len : int'(pos);
				if (p > list_len) begin
					r.st = ile_pkg::ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.st = ile_pkg::ST_FULL;
					n_full++;
				end else begin
					for (int i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
					n_inserts++;
				end
			end
			ile_pkg::OP_DELETE: begin
				if (int'(pos) >= list_len) begin
					r.st = ile_pkg::ST_RANGE;
				end else begin
					for (int i = int'(pos); i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					n_deletes++;
				end
			end
			default: r.st = ile_pkg::ST_RANGE;
		endcase
		if (r.st == ile_pkg::ST_RANGE)
			n_range++;
		if (list_len > peak_len)
			peak_len = list_len;
		r.cnt = list_len[COUNT_O_W-1:0];
		return r;
	endfunction

	// Present one request word, wait for it to be taken, then record what it should give.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input logic has_fixed,
			input list_result_t fixed_res);
		list_result_t r;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = {val, pos};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		r = apply_request(op, pos, val);
		if (has_fixed)
			r = fixed_res;
		pending_q.push_back(r);
		words_in++;
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (pending_q.size() == 0);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Random request; the mix is set by the insert and delete percentages, the rest
	// is mostly reads with a few unknown ops.
	task automatic send_random(input int ins_pct, input int del_pct);
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		int                r;
		int                lim;
		r   = $urandom_range(0, 99);
		pos = POS_W'($urandom);
		if (r < ins_pct) begin
			case ($urandom_range(0, 2))
				0: op = ile_pkg::OP_INS_HEAD;
				1: op = ile_pkg::OP_APPEND;
				default: op = ile_pkg::OP_INS_AT;
			endcase
			if ($urandom_range(0, 9) != 0)
				pos = POS_W'($urandom_range(0, list_len));
			else if ($urandom_range(0, 1) == 0)
				pos = POS_W'(list_len + 1);
		end else if (r < ins_pct + del_pct) begin
			op = ile_pkg::OP_DELETE;
			if (list_len > 0 && $urandom_range(0, 9) != 0)
				pos = POS_W'($urandom_range(0, list_len - 1));
		end else if (r < ins_pct + del_pct + 4) begin
			op = OP_W'($urandom_range(5, 7));
		end else begin
			op = ile_pkg::OP_READ;
			// Reads far down the list are slow, so most stay near the head.
			if (list_len > 0 && $urandom_range(0, 4) != 0) begin
				lim = ($urandom_range(0, 9) < 6 && list_len > 8) ? 7 : list_len - 1;
				pos = POS_W'($urandom_range(0, lim));
			end else if ($urandom_range(0, 1) == 0) begin
				pos = POS_W'(list_len);
			end
		end
		send_word(op, pos, pick_value(), 1'b0, '0);
		random_sent++;
	endtask

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val, input logic has_fixed,
			input logic [DATA_W-1:0] rv, input ile_pkg::status_t st, input int cnt);
		dir_row_t row;
		row.op        = op;
		row.pos       = pos;
		row.val       = val;
		row.has_fixed = has_fixed;
		row.fixed_res = '{rv: rv, st: st, cnt: cnt[COUNT_O_W-1:0]};
		dir_rows.push_back(row);
	endfunction

	// Result side: random stall bursts while gaps are enabled.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// Check every result word against the oldest outstanding expectation.
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_out++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word rv=%h st=%0d cnt=%0d", $realtime,
						m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[40:32]);
			end else begin
				e = pending_q.pop_front();
				if (m_axis_tdata[31:0] !== e.rv || m_axis_tuser !== e.st
						|| m_axis_tdata[40:32] !== e.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: word %0d expected rv=%h st=%0d cnt=%0d, got rv=%h st=%0d cnt=%0d",
							$realtime, words_out, e.rv, e.st, e.cnt, m_axis_tdata[31:0],
							m_axis_tuser, m_axis_tdata[40:32]);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Timeout with %0d results outstanding", pending_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		// Empty list: rejected reads, deletes, inserts past the end and unknown ops.
		add_row(ile_pkg::OP_READ,     16'h0000, 32'h0,         1, ile_pkg::READ_FAIL,
			ile_pkg::ST_RANGE, 0);
		add_row(ile_pkg::OP_READ,     16'hFFFF, 32'h0,         1, ile_pkg::READ_FAIL,
			ile_pkg::ST_RANGE, 0);
		add_row(ile_pkg::OP_DELETE,   16'h0000, 32'h0,         1, 32'h0, ile_pkg::ST_RANGE, 0);
		add_row(ile_pkg::OP_INS_AT,   16'h0001, 32'h5A5A_5A5A, 1, 32'h0, ile_pkg::ST_RANGE, 0);
		add_row(3'd5,                 16'h0000, 32'h1234_5678, 1, 32'h0, ile_pkg::ST_RANGE, 0);
		add_row(3'd7,                 16'hFFFF, 32'hFFFF_FFFF, 1, 32'h0, ile_pkg::ST_RANGE, 0);
		// Build a short list with every insert kind and the value extremes.
		add_row(ile_pkg::OP_INS_AT,   16'h0000, 32'h1234_5678, 1, 32'h0, ile_pkg::ST_DONE,  1);
		add_row(ile_pkg::OP_INS_HEAD, 16'hFFFF, 32'h8000_0000, 1, 32'h0, ile_pkg::ST_DONE,  2);
		add_row(ile_pkg::OP_APPEND,   16'hFFFF, 32'h7FFF_FFFF, 1, 32'h0, ile_pkg::ST_DONE,  3);
		add_row(ile_pkg::OP_INS_AT,   16'h0003, 32'hFFFF_FFFF, 1, 32'h0, ile_pkg::ST_DONE,  4);
		add_row(ile_pkg::OP_INS_AT,   16'h0001, 32'h0000_0000, 1, 32'h0, ile_pkg::ST_DONE,  5);
		add_row(ile_pkg::OP_READ,     16'h0000, 32'h0,         0, 32'h0, ile_pkg::ST_DONE,  0);
		add_row(ile_pkg::OP_READ,     16'h0001, 32'h0,         0, 32'h0, ile_pkg::ST_DONE,  0);
		add_row(ile_pkg::OP_READ,     16'h0004, 32'h0,         0, 32'h0, ile_pkg::ST_DONE,  0);
		add_row(ile_pkg::OP_READ,     16'h0005, 32'h0,         1, ile_pkg::READ_FAIL,
			ile_pkg::ST_RANGE, 5);
		add_row(ile_pkg::OP_INS_AT,   16'h0007, 32'hDEAD_BEEF, 1, 32'h0, ile_pkg::ST_RANGE, 5);
		add_row(ile_pkg::OP_DELETE,   16'h0005, 32'h0,         1, 32'h0, ile_pkg::ST_RANGE, 5);
		add_row(ile_pkg::OP_DELETE,   16'hFFFF, 32'h0,         1, 32'h0, ile_pkg::ST_RANGE, 5);
		add_row(ile_pkg::OP_DELETE,   16'h0004, 32'h0,         1, 32'h0, ile_pkg::ST_DONE,  4);
		add_row(ile_pkg::OP_DELETE,   16'h0000, 32'h0,         1, 32'h0, ile_pkg::ST_DONE,  3);
		add_row(ile_pkg::OP_READ,     16'h0002, 32'h0,         0, 32'h0, ile_pkg::ST_DONE,  0);
		add_row(3'd6,                 16'h8000, 32'h0F0F_0F0F, 1, 32'h0, ile_pkg::ST_RANGE, 3);
		add_row(ile_pkg::OP_INS_HEAD, 16'h0000, 32'hFFFF_FFFF, 1, 32'h0, ile_pkg::ST_DONE,  4);
		add_row(ile_pkg::OP_READ,     16'h0000, 32'h0,         0, 32'h0, ile_pkg::ST_DONE,  0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[k])
			send_word(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val,
				dir_rows[k].has_fixed, dir_rows[k].fixed_res);
		wait_all_results();

		// Fill the list to the top, then press on it while full.
		while (list_len < DEPTH && random_sent < 800)
			send_random(85, 5);
		repeat (40) send_random(80, 0);
		wait_all_results();

		// Drain back to empty.
		while (list_len > 0 && random_sent < 1200)
			send_random(5, 85);

		// Mixed traffic; the tail runs with no idle cycles on either side.
		while (random_sent < RAND_ITEMS) begin
			gaps_on = (random_sent < RAND_ITEMS - QUIET_TAIL);
			send_random(45, 35);
		end
		wait_all_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d requests: %0d reads, %0d inserts, %0d deletes, %0d rejected by range",
			words_in, n_reads, n_inserts, n_deletes, n_range);
		$display("Peak length %0d of %0d, %0d inserts dropped while full, %0d mismatches",
			peak_len, DEPTH, n_full, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
